>>> sv/ifc_pkg.sv
`default_nettype none
package ifc_pkg;
	localparam int VECTOR_BITS      = 32;
	localparam int DEFAULT_MAX_NETS = 32;
	localparam int LEN_W            = 6;
	localparam int CLASS_W          = 4;
	localparam int SIZE_W           = 6;
	localparam int IDX_OUT_W        = 5;
	localparam int COUNT_W          = 6;
	localparam logic [LEN_W-1:0] VLEN_RESET = 6'd32;

	typedef logic [CLASS_W-1:0] class_t;
	localparam class_t CLS_OK      = 4'd0;
	localparam class_t CLS_STUCK0  = 4'd1;
	localparam class_t CLS_STUCK1  = 4'd2;
	localparam class_t CLS_UNKNOWN = 4'd3;
	localparam class_t CLS_WOR     = 4'd4;
	localparam class_t CLS_WAND    = 4'd5;
	localparam class_t CLS_USHORT  = 4'd6;
	localparam class_t CLS_ALIAS   = 4'd7;
	localparam class_t CLS_CONF    = 4'd8;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_NEXT,
		ST_LEAD,
		ST_SRD,
		ST_SCMP,
		ST_CLASS,
		ST_MRD,
		ST_MCMP,
		ST_ORD,
		ST_OSHOW
	} state_t;

	typedef struct packed {
		logic init;
		logic step;
	} match_ctl_t;

	typedef struct packed {
		logic hit;
		logic lead_zero;
		logic lead_ones;
		logic lead_or;
		logic lead_and;
	} match_stat_t;
endpackage
`default_nettype wire

>>> sv/ifc_if.sv
`default_nettype none
interface ifc_net_if;
	logic                             valid;
	logic                             ready;
	logic [ifc_pkg::VECTOR_BITS-1:0]  test_vector;
	logic [ifc_pkg::VECTOR_BITS-1:0]  response_vector;
	logic                             last_net;
	modport source(output valid, test_vector, response_vector, last_net, input ready);
	modport sink(input valid, test_vector, response_vector, last_net, output ready);
endinterface

interface ifc_rec_if;
	logic                             valid;
	logic                             ready;
	logic [ifc_pkg::IDX_OUT_W-1:0]    net_index;
	logic [ifc_pkg::CLASS_W-1:0]      fault_class;
	logic [ifc_pkg::IDX_OUT_W-1:0]    group_leader;
	logic [ifc_pkg::SIZE_W-1:0]       group_size;
	logic [ifc_pkg::COUNT_W-1:0]      detected_count;
	logic [ifc_pkg::COUNT_W-1:0]      isolated_count;
	logic [ifc_pkg::COUNT_W-1:0]      total_count;
	logic                             overflow;
	logic                             last_record;
	modport source(output valid, net_index, fault_class, group_leader, group_size,
		detected_count, isolated_count, total_count, overflow, last_record, input ready);
	modport sink(input valid, net_index, fault_class, group_leader, group_size,
		detected_count, isolated_count, total_count, overflow, last_record, output ready);
endinterface
`default_nettype wire

>>> sv/ifc_ram.sv
`default_nettype none
module ifc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> sv/ifc_match_unit.sv
`default_nettype none
module ifc_match_unit (
	input  wire logic                            clk,
	input  wire ifc_pkg::match_ctl_t             ctl,
	input  wire logic [ifc_pkg::VECTOR_BITS-1:0] mask,
	input  wire logic [ifc_pkg::VECTOR_BITS-1:0] cand_t,
	input  wire logic [ifc_pkg::VECTOR_BITS-1:0] cand_r,
	input  wire logic                            cand_done,
	output ifc_pkg::match_stat_t                 stat
);
	logic [ifc_pkg::VECTOR_BITS-1:0] lead_r_q;
	logic [ifc_pkg::VECTOR_BITS-1:0] or_q;
	logic [ifc_pkg::VECTOR_BITS-1:0] and_q;

	// accumulate test vectors of the group being scanned
	always_ff @(posedge clk) begin
		if (ctl.init) begin
			lead_r_q <= cand_r;
			or_q     <= cand_t;
			and_q    <= cand_t;
		end else if (ctl.step) begin
			or_q  <= or_q | cand_t;
			and_q <= and_q & cand_t;
		end
	end

	always_comb begin
		stat.hit       = !cand_done && (cand_r == lead_r_q);
		stat.lead_zero = (cand_r & mask) == '0;
		stat.lead_ones = (cand_r & mask) == mask;
		stat.lead_or   = lead_r_q == or_q;
		stat.lead_and  = lead_r_q == and_q;
	end
endmodule
`default_nettype wire

>>> sv/interconnect_fault_classifier.sv
// channel  | dir | beat
// nets     | in  | one net: test_vector, response_vector, last_net
// records  | out | one record per stored net after the last net
// cfg      | in  | vector_length write, no handshake
// loading accepts one net per cycle while nets is ready
// diagnosis: each non-stuck group leader makes two scans of the vector memory through
// one compare unit; a stuck leader is classed without a scan
// report: ORD reads a record, OSHOW holds it until taken; nets not ready until done
// reset clears control state only; the stores need no clearing pass
`default_nettype none
module interconnect_fault_classifier #(
	parameter int MAX_NETS = ifc_pkg::DEFAULT_MAX_NETS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [ifc_pkg::LEN_W-1:0] cfg_wdata,
	ifc_net_if.sink                        nets,
	ifc_rec_if.source                      records
);
	localparam int IW   = $clog2(MAX_NETS);
	localparam int CNTW = $clog2(MAX_NETS + 1);
	localparam int VB   = ifc_pkg::VECTOR_BITS;
	localparam int RW   = ifc_pkg::CLASS_W + IW + ifc_pkg::SIZE_W;

	ifc_pkg::state_t state_q, state_d;

	logic [ifc_pkg::LEN_W-1:0] vlen_q;
	logic [CNTW-1:0]           cnt_q, i_q, m_q, n_q, zc_q;
	logic [CNTW-1:0]           det_q, iso_q, ali_q;
	logic                      ovf_q;
	logic [MAX_NETS-1:0]       done_q, differ_q;
	ifc_pkg::class_t           cls_q, cls_d;

	logic [ifc_pkg::LEN_W:0] len_eff;
	logic [VB-1:0]           mask;
	logic [VB-1:0]           t_in, r_in;
	logic                    in_acc, room;

	logic [IW-1:0]   i_idx, m_idx;
	logic [2*VB-1:0] vec_rdata;
	logic [IW-1:0]   vec_raddr;
	logic            res_we;
	logic [IW-1:0]   res_waddr;
	logic [RW-1:0]   res_wdata, res_rdata;

	ifc_pkg::match_ctl_t  mctl;
	ifc_pkg::match_stat_t mstat;
	ifc_pkg::class_t      wcls;
	logic [ifc_pkg::SIZE_W-1:0] wsize;
	logic det_inc, iso_inc, ali_inc, is_stuck, last_rec;

	assign i_idx = i_q[IW-1:0];
	assign m_idx = m_q[IW-1:0];

	// effective length and vector mask
	always_comb begin
		if (vlen_q == '0) begin
			len_eff = (ifc_pkg::LEN_W + 1)'(1);
		end else if ({1'b0, vlen_q} > (ifc_pkg::LEN_W + 1)'(VB)) begin
			len_eff = (ifc_pkg::LEN_W + 1)'(VB);
		end else begin
			len_eff = {1'b0, vlen_q};
		end
		for (int b = 0; b < VB; b++) begin
			mask[b] = (ifc_pkg::LEN_W + 1)'(b) < len_eff;
		end
	end

	assign t_in     = nets.test_vector & mask;
	assign r_in     = nets.response_vector & mask;
	assign in_acc   = nets.valid && nets.ready;
	assign room     = cnt_q < CNTW'(MAX_NETS);
	assign is_stuck = mstat.lead_zero || mstat.lead_ones;
	assign last_rec = (m_q + CNTW'(1)) == cnt_q;

	ifc_ram #(.WIDTH(2 * VB), .DEPTH(MAX_NETS)) u_vec_ram (
		.clk   (clk),
		.we    (in_acc && room),
		.waddr (cnt_q[IW-1:0]),
		.wdata ({t_in, r_in}),
		.raddr (vec_raddr),
		.rdata (vec_rdata)
	);

	ifc_ram #(.WIDTH(RW), .DEPTH(MAX_NETS)) u_res_ram (
		.clk   (clk),
		.we    (res_we),
		.waddr (res_waddr),
		.wdata (res_wdata),
		.raddr (m_idx),
		.rdata (res_rdata)
	);

	ifc_match_unit u_match (
		.clk       (clk),
		.ctl       (mctl),
		.mask      (mask),
		.cand_t    (vec_rdata[2*VB-1:VB]),
		.cand_r    (vec_rdata[VB-1:0]),
		.cand_done (done_q[m_idx]),
		.stat      (mstat)
	);

	// group class from size, alias check and or/and of test vectors
	always_comb begin
		ifc_pkg::class_t short_cls;
		if (mstat.lead_or) begin
			short_cls = ifc_pkg::CLS_WOR;
		end else if (mstat.lead_and) begin
			short_cls = ifc_pkg::CLS_WAND;
		end else begin
			short_cls = ifc_pkg::CLS_USHORT;
		end
		if (n_q == CNTW'(1)) begin
			cls_d = ifc_pkg::CLS_UNKNOWN;
		end else if (n_q == CNTW'(2)) begin
			cls_d = short_cls;
		end else if (n_q == CNTW'(3)) begin
			cls_d = (zc_q == CNTW'(1)) ? ifc_pkg::CLS_ALIAS : short_cls;
		end else begin
			cls_d = ifc_pkg::CLS_CONF;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ifc_pkg::ST_LOAD: begin
				if (in_acc && nets.last_net) begin
					state_d = ifc_pkg::ST_NEXT;
				end
			end
			ifc_pkg::ST_NEXT: begin
				if (i_q == cnt_q) begin
					state_d = ifc_pkg::ST_ORD;
				end else if (differ_q[i_idx] && !done_q[i_idx]) begin
					state_d = ifc_pkg::ST_LEAD;
				end
			end
			ifc_pkg::ST_LEAD: begin
				state_d = is_stuck ? ifc_pkg::ST_NEXT : ifc_pkg::ST_SRD;
			end
			ifc_pkg::ST_SRD: begin
				state_d = (m_q == cnt_q) ? ifc_pkg::ST_CLASS : ifc_pkg::ST_SCMP;
			end
			ifc_pkg::ST_SCMP:  state_d = ifc_pkg::ST_SRD;
			ifc_pkg::ST_CLASS: state_d = ifc_pkg::ST_MRD;
			ifc_pkg::ST_MRD: begin
				state_d = (m_q == cnt_q) ? ifc_pkg::ST_NEXT : ifc_pkg::ST_MCMP;
			end
			ifc_pkg::ST_MCMP:  state_d = ifc_pkg::ST_MRD;
			ifc_pkg::ST_ORD:   state_d = ifc_pkg::ST_OSHOW;
			ifc_pkg::ST_OSHOW: begin
				if (records.ready) begin
					state_d = last_rec ? ifc_pkg::ST_LOAD : ifc_pkg::ST_ORD;
				end
			end
			default: state_d = ifc_pkg::ST_LOAD;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		nets.ready = state_q == ifc_pkg::ST_LOAD;
		vec_raddr  = (state_q == ifc_pkg::ST_NEXT) ? i_idx : m_idx;
		mctl.init  = state_q == ifc_pkg::ST_LEAD;
		mctl.step  = (state_q == ifc_pkg::ST_SCMP) && mstat.hit && (m_q != i_q);
		res_we     = 1'b0;
		res_waddr  = m_idx;
		wcls       = cls_q;
		wsize      = ifc_pkg::SIZE_W'(n_q);
		if (state_q == ifc_pkg::ST_LEAD) begin
			res_we    = is_stuck;
			res_waddr = i_idx;
			wcls      = mstat.lead_zero ? ifc_pkg::CLS_STUCK0 : ifc_pkg::CLS_STUCK1;
			wsize     = ifc_pkg::SIZE_W'(1);
		end else if (state_q == ifc_pkg::ST_MCMP) begin
			res_we = mstat.hit;
		end
		res_wdata = {wcls, i_idx, wsize};
		det_inc   = res_we && (wcls != ifc_pkg::CLS_ALIAS);
		iso_inc   = res_we && (wcls != ifc_pkg::CLS_ALIAS) && (wcls != ifc_pkg::CLS_CONF);
		ali_inc   = res_we && (wcls == ifc_pkg::CLS_ALIAS);
	end

	always_comb begin
		records.valid          = state_q == ifc_pkg::ST_OSHOW;
		records.net_index      = ifc_pkg::IDX_OUT_W'(m_q);
		records.detected_count = ifc_pkg::COUNT_W'(det_q);
		records.isolated_count = ifc_pkg::COUNT_W'(iso_q);
		records.total_count    = ifc_pkg::COUNT_W'(det_q + ali_q);
		records.overflow       = ovf_q;
		records.last_record    = last_rec;
		if (done_q[m_idx]) begin
			records.fault_class  = res_rdata[RW-1 -: ifc_pkg::CLASS_W];
			records.group_leader = ifc_pkg::IDX_OUT_W'(res_rdata[ifc_pkg::SIZE_W +: IW]);
			records.group_size   = res_rdata[ifc_pkg::SIZE_W-1:0];
		end else begin
			records.fault_class  = ifc_pkg::CLS_OK;
			records.group_leader = ifc_pkg::IDX_OUT_W'(m_q);
			records.group_size   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q <= ifc_pkg::VLEN_RESET;
		end else if (cfg_we) begin
			vlen_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ifc_pkg::ST_LOAD;
			cnt_q    <= '0;
			i_q      <= '0;
			m_q      <= '0;
			n_q      <= '0;
			zc_q     <= '0;
			det_q    <= '0;
			iso_q    <= '0;
			ali_q    <= '0;
			ovf_q    <= 1'b0;
			done_q   <= '0;
			differ_q <= '0;
			cls_q    <= ifc_pkg::CLS_OK;
		end else begin
			state_q <= state_d;
			if (det_inc) begin
				det_q <= det_q + CNTW'(1);
			end
			if (iso_inc) begin
				iso_q <= iso_q + CNTW'(1);
			end
			if (ali_inc) begin
				ali_q <= ali_q + CNTW'(1);
			end
			if (res_we) begin
				done_q[res_waddr] <= 1'b1;
			end
			case (state_q)
				ifc_pkg::ST_LOAD: begin
					if (in_acc) begin
						if (room) begin
							differ_q[cnt_q[IW-1:0]] <= t_in != r_in;
							cnt_q                   <= cnt_q + CNTW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						i_q <= '0;
					end
				end
				ifc_pkg::ST_NEXT: begin
					if (i_q == cnt_q) begin
						m_q <= '0;
					end else if (!(differ_q[i_idx] && !done_q[i_idx])) begin
						i_q <= i_q + CNTW'(1);
					end
				end
				ifc_pkg::ST_LEAD: begin
					if (is_stuck) begin
						i_q <= i_q + CNTW'(1);
					end
					m_q  <= '0;
					n_q  <= CNTW'(1);
					zc_q <= '0;
				end
				ifc_pkg::ST_SCMP: begin
					if (mctl.step) begin
						n_q <= n_q + CNTW'(1);
						if (!differ_q[m_idx]) begin
							zc_q <= zc_q + CNTW'(1);
						end
					end
					m_q <= m_q + CNTW'(1);
				end
				ifc_pkg::ST_CLASS: begin
					cls_q <= cls_d;
					m_q   <= '0;
				end
				ifc_pkg::ST_MRD: begin
					if (m_q == cnt_q) begin
						i_q <= i_q + CNTW'(1);
					end
				end
				ifc_pkg::ST_MCMP: begin
					m_q <= m_q + CNTW'(1);
				end
				ifc_pkg::ST_OSHOW: begin
					if (records.ready) begin
						if (last_rec) begin
							cnt_q  <= '0;
							ovf_q  <= 1'b0;
							done_q <= '0;
							det_q  <= '0;
							iso_q  <= '0;
							ali_q  <= '0;
							m_q    <= '0;
						end else begin
							m_q <= m_q + CNTW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps
module tb;
	localparam int NET_CAP   = ifc_pkg::DEFAULT_MAX_NETS;
	localparam int WAIT_LIMIT = 20000;
	localparam int NET_GOAL  = 260;

	typedef struct {
		int              net_index;
		ifc_pkg::class_t fault_class;
		int              group_leader;
		int              group_size;
		int              detected_count;
		int              isolated_count;
		int              total_count;
		bit              overflow;
		bit              last_record;
	} net_record_t;

	class fault_board;
		logic [ifc_pkg::VECTOR_BITS-1:0] tvec[NET_CAP];
		logic [ifc_pkg::VECTOR_BITS-1:0] rvec[NET_CAP];
		bit [1:0]                        status[NET_CAP];
		ifc_pkg::class_t                 cls[NET_CAP];
		int                              leader[NET_CAP];
		int                              gsize[NET_CAP];
		int                              members[NET_CAP];
		int                              n_members;
		int                              n_nets;
		bit                              dropped;
		int                              vlen = 32;
		net_record_t                     due[$];
		int                              errors;

		function logic [ifc_pkg::VECTOR_BITS-1:0] len_mask();
			int n;
			n = vlen;
			if (n < 1) n = 1;
			if (n > ifc_pkg::VECTOR_BITS) n = ifc_pkg::VECTOR_BITS;
			if (n == ifc_pkg::VECTOR_BITS) return '1;
			return (32'h1 << n) - 32'h1;
		endfunction

		task report(string what);
			$display("%0t mismatch: %s", $time, what);
			errors++;
		endtask

		function void mark_group(ifc_pkg::class_t c, int lead);
			for (int k = 0; k < n_members; k++) begin
				status[members[k]] = 2'd2;
				cls[members[k]] = c;
				leader[members[k]] = lead;
				gsize[members[k]] = n_members;
			end
		endfunction

		function ifc_pkg::class_t short_kind(logic [31:0] resp, logic [31:0] orv,
			logic [31:0] andv);
			if (resp == orv) return ifc_pkg::CLS_WOR;
			if (resp == andv) return ifc_pkg::CLS_WAND;
			return ifc_pkg::CLS_USHORT;
		endfunction

		function void classify_nets();
			logic [ifc_pkg::VECTOR_BITS-1:0] m, resp;
			bit jz, kz;
			m = len_mask();
			for (int i = 0; i < n_nets; i++) begin
				cls[i] = ifc_pkg::CLS_OK;
				leader[i] = i;
				gsize[i] = 0;
			end
			for (int i = 0; i < n_nets; i++) begin
				if (status[i] != 2'd1) continue;
				resp = rvec[i];
				members[0] = i;
				n_members = 1;
				if ((resp & m) == '0) begin
					mark_group(ifc_pkg::CLS_STUCK0, i);
					continue;
				end
				if ((resp & m) == m) begin
					mark_group(ifc_pkg::CLS_STUCK1, i);
					continue;
				end
				for (int j = 0; j < n_nets; j++)
					if (j != i && status[j] != 2'd2 && rvec[j] == resp) begin
						members[n_members] = j;
						n_members++;
					end
				if (n_members == 1) mark_group(ifc_pkg::CLS_UNKNOWN, i);
				else if (n_members == 2)
					mark_group(short_kind(resp, tvec[i] | tvec[members[1]],
						tvec[i] & tvec[members[1]]), i);
				else if (n_members == 3) begin
					jz = status[members[1]] == 2'd0;
					kz = status[members[2]] == 2'd0;
					if (jz != kz) mark_group(ifc_pkg::CLS_ALIAS, i);
					else mark_group(short_kind(resp,
						tvec[i] | tvec[members[1]] | tvec[members[2]],
						tvec[i] & tvec[members[1]] & tvec[members[2]]), i);
				end else mark_group(ifc_pkg::CLS_CONF, i);
			end
		endfunction

		function void note_net(logic [31:0] t, logic [31:0] r, bit last);
			logic [ifc_pkg::VECTOR_BITS-1:0] m;
			int det, iso, ali;
			net_record_t rec;
			m = len_mask();
			if (n_nets < NET_CAP) begin
				tvec[n_nets] = t & m;
				rvec[n_nets] = r & m;
				status[n_nets] = ((t & m) != (r & m)) ? 2'd1 : 2'd0;
				n_nets++;
			end else dropped = 1;
			if (!last) return;
			classify_nets();
			det = 0;
			iso = 0;
			ali = 0;
			for (int i = 0; i < n_nets; i++) begin
				if (cls[i] >= ifc_pkg::CLS_STUCK0 && cls[i] <= ifc_pkg::CLS_USHORT) begin
					det++;
					iso++;
				end else if (cls[i] == ifc_pkg::CLS_CONF) det++;
				else if (cls[i] == ifc_pkg::CLS_ALIAS) ali++;
			end
			for (int i = 0; i < n_nets; i++) begin
				rec.net_index = i;
				rec.fault_class = cls[i];
				rec.group_leader = leader[i];
				rec.group_size = gsize[i];
				rec.detected_count = det;
				rec.isolated_count = iso;
				rec.total_count = det + ali;
				rec.overflow = dropped;
				rec.last_record = (i + 1 == n_nets);
				due.insert(due.size(), rec);
			end
			n_nets = 0;
			dropped = 0;
		endfunction

		task cmp(string name, int got, int want);
			if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
		endtask

		task check_record(net_record_t got);
			net_record_t want;
			if (due.size() == 0) begin
				report($sformatf("record for net %0d with none pending", got.net_index));
				return;
			end
			want = due.pop_front();
			cmp("net_index", got.net_index, want.net_index);
			cmp("fault_class", got.fault_class, want.fault_class);
			cmp("group_leader", got.group_leader, want.group_leader);
			cmp("group_size", got.group_size, want.group_size);
			cmp("detected_count", got.detected_count, want.detected_count);
			cmp("isolated_count", got.isolated_count, want.isolated_count);
			cmp("total_count", got.total_count, want.total_count);
			cmp("overflow", got.overflow, want.overflow);
			cmp("last_record", got.last_record, want.last_record);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ifc_pkg::LEN_W-1:0] cfg_wdata;
	bit calm;
	int quiet_cycles;
	int nets_sent;
	fault_board board;

	ifc_net_if nets_if();
	ifc_rec_if rec_if();

	interconnect_fault_classifier u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.nets     (nets_if),
		.records  (rec_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// record sink with random backpressure
	always @(negedge clk) begin
		rec_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 18);
	end

	always @(posedge clk) begin
		net_record_t got;
		if (arst_n && rec_if.valid && rec_if.ready) begin
			got.net_index = int'(rec_if.net_index);
			got.fault_class = rec_if.fault_class;
			got.group_leader = int'(rec_if.group_leader);
			got.group_size = int'(rec_if.group_size);
			got.detected_count = int'(rec_if.detected_count);
			got.isolated_count = int'(rec_if.isolated_count);
			got.total_count = int'(rec_if.total_count);
			got.overflow = rec_if.overflow;
			got.last_record = rec_if.last_record;
			board.check_record(got);
		end
	end

	always @(posedge clk) begin
		if ((nets_if.valid && nets_if.ready) || (rec_if.valid && rec_if.ready))
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WAIT_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_net(logic [31:0] t, logic [31:0] r, bit last);
		while (!calm && $urandom_range(0, 99) < 18) begin
			nets_if.valid = 1'b0;
			@(negedge clk);
		end
		nets_if.valid = 1'b1;
		nets_if.test_vector = t;
		nets_if.response_vector = r;
		nets_if.last_net = last;
		do @(posedge clk); while (!nets_if.ready);
		board.note_net(t, r, last);
		nets_sent++;
		@(negedge clk);
	endtask

	task automatic send_set(logic [31:0] ts[$], logic [31:0] rs[$]);
		for (int i = 0; i < ts.size(); i++) send_net(ts[i], rs[i], i == ts.size() - 1);
		nets_if.valid = 1'b0;
	endtask

	task automatic drain_and_config(int len);
		while (board.due.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = ifc_pkg::LEN_W'(len);
		board.vlen = len;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_set(int n);
		logic [31:0] ts[$], rs[$], pool[4], m, t, r;
		int mode;
		m = board.len_mask();
		foreach (pool[k]) pool[k] = $urandom;
		for (int i = 0; i < n; i++) begin
			t = $urandom;
			mode = $urandom_range(0, 8);
			case (mode)
				0: r = t;
				1: r = $urandom & ~m;
				2: r = $urandom | m;
				3: r = $urandom;
				4, 5: begin
					if (i > 0) begin
						r = (mode == 4) ? (ts[i-1] | t) : (ts[i-1] & t);
						rs[i-1] = r;
					end else r = $urandom;
				end
				6: r = pool[$urandom_range(0, 3)];
				7: begin
					r = pool[0];
					if ($urandom_range(0, 1)) t = r;
				end
				default: r = pool[1];
			endcase
			ts = {ts, t};
			rs = {rs, r};
		end
		send_set(ts, rs);
	endtask

	initial begin
		logic [31:0] ts[$], rs[$];
		int set_no;
		int lens[4];
		lens = '{1, 32, 0, 63};
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		calm = 1'b0;
		nets_if.valid = 1'b0;
		nets_if.test_vector = '0;
		nets_if.response_vector = '0;
		nets_if.last_net = 1'b0;
		rec_if.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// ok, stuck, unknown, or/and/other shorts, aliasing, confounding
		ts = '{32'h1357_9bdf, 32'h5, 32'h1, 32'h3, 32'h0f0, 32'h00f, 32'hff0, 32'h0ff,
			32'h100, 32'h200, 32'ha, 32'hc, 32'hb, 32'h1, 32'h2, 32'h4, 32'h8};
		rs = '{32'h1357_9bdf, 32'h0, 32'hffff_ffff, 32'h1234, 32'h0ff, 32'h0ff, 32'h0f0,
			32'h0f0, 32'h777, 32'h777, 32'hb, 32'hb, 32'hb, 32'h55, 32'h55, 32'h55, 32'h55};
		send_set(ts, rs);
		drain_and_config(1);
		ts = '{32'hffff_fffe, 32'h1};
		rs = '{32'h0000_0001, 32'hffff_fffe};
		send_set(ts, rs);
		drain_and_config(0);
		ts = '{32'h1};
		rs = '{32'h0};
		send_set(ts, rs);
		drain_and_config(63);
		ts = '{32'h0, 32'hffff_ffff};
		rs = '{32'hffff_ffff, 32'hffff_ffff};
		send_set(ts, rs);

		set_no = 0;
		while (nets_sent < NET_GOAL) begin
			calm = (set_no >= 8 && set_no < 14);
			if ($urandom_range(0, 2) == 0)
				drain_and_config($urandom_range(0, 1) ? lens[$urandom_range(0, 3)]
					: $urandom_range(1, 32));
			if (set_no == 5) random_set(NET_CAP + 3);
			else if ($urandom_range(0, 9) == 0) random_set($urandom_range(9, NET_CAP));
			else random_set($urandom_range(1, 8));
			set_no++;
		end
		calm = 1'b0;

		while (board.due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule

>>> filelist.f
sv/ifc_pkg.sv
sv/ifc_if.sv
sv/ifc_ram.sv
sv/ifc_match_unit.sv
sv/interconnect_fault_classifier.sv
verif/tb.sv
